// ===== rtl/core/tvx_pkg.sv =====
package tvx_pkg;

   localparam int GAIN_FRAC_BITS = 23;
   localparam int SAMPLE_BITS    = 16;

   localparam int GAIN_W  = GAIN_FRAC_BITS + 1;
   localparam int RAMP_W  = GAIN_W + 1;
   localparam int FRAME_W = 20;
   localparam int MV_W    = 16;
   localparam int MASK_W  = 12;
   localparam int FG_W    = GAIN_W + 1;
   localparam int OPA_W   = FG_W + 1;
   localparam int OPB_W   = SAMPLE_BITS + 1;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int NUM_W   = ((GAIN_W > FRAME_W) ? GAIN_W : FRAME_W) + 1;
   localparam int CNT_W   = $clog2(NUM_W + 1);

   localparam logic [GAIN_W-1:0] ONE_GAIN   = GAIN_W'(1) << GAIN_FRAC_BITS;
   localparam logic [GAIN_W-1:0] FREE_LEVEL =
      GAIN_W'(((64'd1 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic [3:0]  NO_NOTE    = 4'd15;
   localparam logic [3:0]  MAX_PITCH  = 4'd11;

   localparam logic [MV_W-1:0]    MV_RESET = 16'd16384;
   localparam logic [FRAME_W-1:0] CF_RESET = 20'd72000;
   localparam logic [FRAME_W-1:0] RF_RESET = 20'd120000;
   localparam logic [FRAME_W-1:0] FF_RESET = 20'd4800;

   typedef enum logic [2:0] {
      FUNC_FRAME    = 3'd0,
      FUNC_NOTE_ON  = 3'd1,
      FUNC_NOTE_OFF = 3'd2,
      FUNC_KILL     = 3'd3,
      FUNC_ENABLE   = 3'd4,
      FUNC_DISABLE  = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      REG_MASTER_VOLUME = 3'd0,
      REG_CROSSFADE     = 3'd1,
      REG_RELEASE       = 3'd2,
      REG_FAST_FADE     = 3'd3,
      REG_LOADED_MASK   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic               start;
      logic [GAIN_W-1:0]  dividend;
      logic [FRAME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [GAIN_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/tvx_div.sv =====
module tvx_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tvx_pkg::div_req_type req,
   output tvx_pkg::div_rsp_type rsp
);
   import tvx_pkg::*;

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [FRAME_W-1:0] den_ff, den_in;
   logic [FRAME_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [FRAME_W:0]   shifted;
   logic [FRAME_W-1:0] den_use;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      den_use = (req.divisor == '0) ? FRAME_W'(1) : req.divisor;
      shifted = {rem_ff, num_ff[NUM_W-1]};
      if (req.start) begin
         // ceiling: divide dividend + divisor - 1
         num_in  = NUM_W'(req.dividend) + NUM_W'(den_use) - NUM_W'(1);
         den_in  = den_use;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = FRAME_W'(shifted - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[FRAME_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff[GAIN_W-1:0];

endmodule

// ===== rtl/core/two_voice_crossfade_mixer_top.sv =====
// Two-voice crossfade mixer.
// Request channel (req_*): one item per request, func selects a frame (mix
// the voice samples) or a control action (note on/off, kill, enable,
// disable). Every request yields exactly one response on rsp_*.
// Register port (csr_*): writes master volume, ramp lengths and the loaded
// mask; always ready, write only while no request is in flight.
// A single multiplier and a bit-serial divider are shared under a sequencer;
// the block takes one request at a time (req_ready low while busy).
// Frames pass each active voice through the multiplier steps; note on,
// note off and disable wait on the bit-serial divider to compute their
// ramps; other controls go straight to the response.
// The response sits in an output register; a stalled receiver (rsp_ready
// low) holds it, and the next request is accepted and worked on meanwhile,
// waiting only to hand over its own response.
// Reset (synchronous, active high) restores register defaults, disables
// note-on, clears all voices and drops any pending response.
module two_voice_crossfade_mixer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic [3:0]                          req_pitch_class,
   input  logic signed [tvx_pkg::SAMPLE_BITS-1:0] req_voice0_left,
   input  logic signed [tvx_pkg::SAMPLE_BITS-1:0] req_voice0_right,
   input  logic signed [tvx_pkg::SAMPLE_BITS-1:0] req_voice1_left,
   input  logic signed [tvx_pkg::SAMPLE_BITS-1:0] req_voice1_right,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tvx_pkg::SAMPLE_BITS-1:0] rsp_mix_left,
   output logic signed [tvx_pkg::SAMPLE_BITS-1:0] rsp_mix_right,
   output logic                                rsp_voice0_on,
   output logic                                rsp_voice1_on,
   output logic [3:0]                          rsp_voice0_note,
   output logic [3:0]                          rsp_voice1_note,
   output logic                                rsp_restart_voice0,
   output logic                                rsp_restart_voice1,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [tvx_pkg::FRAME_W-1:0]         csr_data
);
   import tvx_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_STEP  = 10'b0000000010,
      S_MG    = 10'b0000000100,
      S_FG    = 10'b0000001000,
      S_ML    = 10'b0000010000,
      S_MR    = 10'b0000100000,
      S_AC    = 10'b0001000000,
      S_DSEL  = 10'b0010000000,
      S_DWAIT = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [MV_W-1:0]    mv_ff, mv_in;
   logic [FRAME_W-1:0] cf_ff, cf_in, rf_ff, rf_in, fff_ff, fff_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   // voice state
   logic               en_ff, en_in;
   logic [3:0]         last_ff, last_in;
   logic               act_ff [2];
   logic               act_in [2];
   logic [GAIN_W-1:0]  gain_ff [2];
   logic [GAIN_W-1:0]  gain_in [2];
   logic               tup_ff [2];
   logic               tup_in [2];
   logic signed [RAMP_W-1:0] ramp_ff [2];
   logic signed [RAMP_W-1:0] ramp_in [2];
   logic [3:0]         pitch_ff [2];
   logic [3:0]         pitch_in [2];

   // item and datapath
   func_type           func_ff, func_in;
   logic [3:0]         pc_ff, pc_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff [4];
   logic signed [SAMPLE_BITS-1:0] smp_in [4];
   logic               vi_ff, vi_in;
   logic [1:0]         job_ff, job_in;
   logic [FG_W-1:0]    fg_ff, fg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  accl_ff, accl_in, accr_ff, accr_in;
   logic               rst0_ff, rst0_in, rst1_ff, rst1_in;

   // response register
   logic               rv_ff, rv_in;
   logic signed [SAMPLE_BITS-1:0] ml_ff, ml_in, mr_ff, mr_in;
   logic               on0_ff, on0_in, on1_ff, on1_in;
   logic [3:0]         nt0_ff, nt0_in, nt1_ff, nt1_in;
   logic               ro0_ff, ro0_in, ro1_ff, ro1_in;

   div_req_type        dreq;
   div_rsp_type        drsp;

   logic signed [OPA_W-1:0] opa;
   logic signed [OPB_W-1:0] opb;
   logic [GAIN_W-1:0]       tgt;
   logic signed [RAMP_W:0]  gsum;
   logic [GAIN_W-1:0]       gstep;
   logic [PROD_W-1:0]       fg_round;
   logic                    pick;
   logic                    on_ok;
   logic [FRAME_W-1:0]      fade_frames;
   logic signed [RAMP_W-1:0] neg_q;

   tvx_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W:0] t;
      logic signed [ACC_W:0] hi;
      logic signed [ACC_W:0] lo;
      hi = (ACC_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
      lo = -hi - (ACC_W+1)'(1);
      t  = ($signed({acc[ACC_W-1], acc}) + ((ACC_W+1)'(1) <<< (GAIN_FRAC_BITS - 1)))
           >>> GAIN_FRAC_BITS;
      if (t > hi) begin
         round_sat = hi[SAMPLE_BITS-1:0];
      end else if (t < lo) begin
         round_sat = lo[SAMPLE_BITS-1:0];
      end else begin
         round_sat = t[SAMPLE_BITS-1:0];
      end
   endfunction

   // envelope step of voice vi
   always_comb begin
      tgt   = tup_ff[vi_ff] ? ONE_GAIN : '0;
      gsum  = $signed({2'b00, gain_ff[vi_ff]}) + (RAMP_W+1)'(ramp_ff[vi_ff]);
      gstep = gain_ff[vi_ff];
      if (ramp_ff[vi_ff] > 0 && gain_ff[vi_ff] < tgt) begin
         gstep = (gsum > $signed({2'b00, tgt})) ? tgt : gsum[GAIN_W-1:0];
      end else if (ramp_ff[vi_ff] < 0 && gain_ff[vi_ff] > tgt) begin
         gstep = (gsum < $signed({2'b00, tgt})) ? tgt : gsum[GAIN_W-1:0];
      end
   end

   // shared multiplier operands
   always_comb begin
      opa = $signed({1'b0, fg_ff});
      opb = {smp_ff[{vi_ff, 1'b0}][SAMPLE_BITS-1], smp_ff[{vi_ff, 1'b0}]};
      priority case (1'b1)
         state_ff == S_MG: begin
            opa = $signed({2'b00, gain_ff[vi_ff]});
            opb = $signed({1'b0, mv_ff});
         end
         state_ff == S_MR: begin
            opb = {smp_ff[{vi_ff, 1'b1}][SAMPLE_BITS-1], smp_ff[{vi_ff, 1'b1}]};
         end
         default: ;
      endcase
   end

   assign fg_round = PROD_W'(prod_ff) + PROD_W'(16384);
   assign pick     = !act_ff[0] ? 1'b0 : (!act_ff[1] ? 1'b1 : (gain_ff[1] < gain_ff[0]));
   assign on_ok    = en_ff && (req_pitch_class <= MAX_PITCH)
                     && mask_ff[req_pitch_class] && (req_pitch_class != last_ff);
   assign fade_frames = (func_ff == FUNC_NOTE_ON) ? cf_ff : rf_ff;
   assign neg_q    = RAMP_W'(-$signed({1'b0, drsp.quotient}));

   always_comb begin
      state_in = state_ff;
      mv_in = mv_ff; cf_in = cf_ff; rf_in = rf_ff; fff_in = fff_ff; mask_in = mask_ff;
      en_in = en_ff; last_in = last_ff;
      act_in = act_ff; gain_in = gain_ff; tup_in = tup_ff;
      ramp_in = ramp_ff; pitch_in = pitch_ff;
      func_in = func_ff; pc_in = pc_ff; smp_in = smp_ff;
      vi_in = vi_ff; job_in = job_ff; fg_in = fg_ff;
      prod_in = PROD_W'(opa * opb);
      accl_in = accl_ff; accr_in = accr_ff;
      rst0_in = rst0_ff; rst1_in = rst1_ff;
      rv_in = rv_ff && !rsp_ready;
      ml_in = ml_ff; mr_in = mr_ff; on0_in = on0_ff; on1_in = on1_ff;
      nt0_in = nt0_ff; nt1_in = nt1_ff; ro0_in = ro0_ff; ro1_in = ro1_ff;
      dreq.start    = 1'b0;
      dreq.dividend = gain_ff[job_ff[0]];
      dreq.divisor  = fade_frames;

      if (csr_valid) begin
         unique case (csr_index)
            REG_MASTER_VOLUME: mv_in   = csr_data[MV_W-1:0];
            REG_CROSSFADE:     cf_in   = csr_data;
            REG_RELEASE:       rf_in   = csr_data;
            REG_FAST_FADE:     fff_in  = csr_data;
            REG_LOADED_MASK:   mask_in = csr_data[MASK_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = func_type'(req_func);
               pc_in   = req_pitch_class;
               smp_in[0] = req_voice0_left;
               smp_in[1] = req_voice0_right;
               smp_in[2] = req_voice1_left;
               smp_in[3] = req_voice1_right;
               accl_in = '0;
               accr_in = '0;
               rst0_in = 1'b0;
               rst1_in = 1'b0;
               vi_in   = 1'b0;
               job_in  = 2'd0;
               state_in = S_OUT;
               unique case (req_func)
                  FUNC_FRAME:   state_in = S_STEP;
                  FUNC_NOTE_ON: if (on_ok) state_in = S_DSEL;
                  FUNC_NOTE_OFF: begin
                     last_in  = NO_NOTE;
                     state_in = S_DSEL;
                  end
                  FUNC_KILL: begin
                     last_in = NO_NOTE;
                     for (int i = 0; i < 2; i++) begin
                        if (act_ff[i]) begin
                           gain_in[i] = '0;
                           tup_in[i]  = 1'b0;
                           act_in[i]  = 1'b0;
                        end
                     end
                  end
                  FUNC_ENABLE: en_in = 1'b1;
                  FUNC_DISABLE: begin
                     en_in    = 1'b0;
                     last_in  = NO_NOTE;
                     job_in   = 2'd2;
                     state_in = S_DSEL;
                  end
                  default: ;
               endcase
            end
         end
         S_STEP: begin
            if (act_ff[vi_ff]) begin
               gain_in[vi_ff] = gstep;
               state_in = S_MG;
            end else if (vi_ff) begin
               state_in = S_OUT;
            end else begin
               vi_in = 1'b1;
            end
         end
         S_MG: state_in = S_FG;
         S_FG: begin
            fg_in    = FG_W'(fg_round >> 15);
            state_in = S_ML;
         end
         S_ML: state_in = S_MR;
         S_MR: begin
            accl_in  = accl_ff + ACC_W'(prod_ff);
            state_in = S_AC;
         end
         S_AC: begin
            accr_in = accr_ff + ACC_W'(prod_ff);
            if (!tup_ff[vi_ff] && gain_ff[vi_ff] <= FREE_LEVEL) act_in[vi_ff] = 1'b0;
            if (vi_ff) begin
               state_in = S_OUT;
            end else begin
               vi_in    = 1'b1;
               state_in = S_STEP;
            end
         end
         S_DSEL: begin
            if (job_ff == 2'd2) begin
               if (func_ff == FUNC_NOTE_OFF) begin
                  state_in = S_OUT;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = ONE_GAIN;
                  dreq.divisor  = (func_ff == FUNC_NOTE_ON) ? cf_ff : fff_ff;
                  state_in      = S_DWAIT;
               end
            end else if (act_ff[job_ff[0]]) begin
               dreq.start = 1'b1;
               state_in   = S_DWAIT;
            end else begin
               job_in = job_ff + 2'd1;
            end
         end
         S_DWAIT: begin
            if (drsp.done) begin
               if (job_ff != 2'd2) begin
                  ramp_in[job_ff[0]] = neg_q;
                  tup_in[job_ff[0]]  = 1'b0;
                  job_in   = job_ff + 2'd1;
                  state_in = S_DSEL;
               end else begin
                  if (func_ff == FUNC_NOTE_ON) begin
                     pitch_in[pick] = pc_ff;
                     gain_in[pick]  = '0;
                     tup_in[pick]   = 1'b1;
                     ramp_in[pick]  = $signed({1'b0, drsp.quotient});
                     act_in[pick]   = 1'b1;
                     last_in        = pc_ff;
                     rst0_in        = !pick;
                     rst1_in        = pick;
                  end else begin
                     for (int i = 0; i < 2; i++) begin
                        ramp_in[i] = neg_q;
                        tup_in[i]  = 1'b0;
                     end
                  end
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in  = 1'b1;
               ml_in  = (func_ff == FUNC_FRAME) ? round_sat(accl_ff) : '0;
               mr_in  = (func_ff == FUNC_FRAME) ? round_sat(accr_ff) : '0;
               on0_in = act_ff[0];
               on1_in = act_ff[1];
               nt0_in = pitch_ff[0];
               nt1_in = pitch_ff[1];
               ro0_in = rst0_ff;
               ro1_in = rst1_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; pc_ff <= pc_in; smp_ff <= smp_in;
      vi_ff <= vi_in; job_ff <= job_in; fg_ff <= fg_in; prod_ff <= prod_in;
      accl_ff <= accl_in; accr_ff <= accr_in;
      rst0_ff <= rst0_in; rst1_ff <= rst1_in;
      ml_ff <= ml_in; mr_ff <= mr_in; on0_ff <= on0_in; on1_ff <= on1_in;
      nt0_ff <= nt0_in; nt1_ff <= nt1_in; ro0_ff <= ro0_in; ro1_ff <= ro1_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         mv_ff    <= MV_RESET;
         cf_ff    <= CF_RESET;
         rf_ff    <= RF_RESET;
         fff_ff   <= FF_RESET;
         mask_ff  <= '0;
         en_ff    <= 1'b0;
         last_ff  <= NO_NOTE;
         for (int i = 0; i < 2; i++) begin
            act_ff[i]   <= 1'b0;
            gain_ff[i]  <= '0;
            tup_ff[i]   <= 1'b0;
            ramp_ff[i]  <= '0;
            pitch_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         mv_ff    <= mv_in;
         cf_ff    <= cf_in;
         rf_ff    <= rf_in;
         fff_ff   <= fff_in;
         mask_ff  <= mask_in;
         en_ff    <= en_in;
         last_ff  <= last_in;
         act_ff   <= act_in;
         gain_ff  <= gain_in;
         tup_ff   <= tup_in;
         ramp_ff  <= ramp_in;
         pitch_ff <= pitch_in;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rv_ff;
   assign rsp_mix_left       = ml_ff;
   assign rsp_mix_right      = mr_ff;
   assign rsp_voice0_on      = on0_ff;
   assign rsp_voice1_on      = on1_ff;
   assign rsp_voice0_note    = nt0_ff;
   assign rsp_voice1_note    = nt1_ff;
   assign rsp_restart_voice0 = ro0_ff;
   assign rsp_restart_voice1 = ro1_ff;

   // the divider only runs while the sequencer waits on it
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      drsp.busy |-> (state_ff == S_DWAIT))
      else $error("divider busy outside ramp wait");

   // a note-on restarts at most one voice
   a_one_restart: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !(ro0_ff && ro1_ff))
      else $error("both voices restarted");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (gain_ff[0] <= ONE_GAIN) && (gain_ff[1] <= ONE_GAIN))
      else $error("gain above unity");

   a_ramp_dir: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (func_ff == FUNC_DISABLE) |-> !tup_ff[0] && !tup_ff[1])
      else $error("voice still rising after disable");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tvx_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1550;

   typedef struct packed {
      logic [2:0]         func;
      logic [3:0]         pitch;
      logic signed [15:0] v0l;
      logic signed [15:0] v0r;
      logic signed [15:0] v1l;
      logic signed [15:0] v1r;
   } mix_request_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               on0;
      logic               on1;
      logic [3:0]         note0;
      logic [3:0]         note1;
      logic               rs0;
      logic               rs1;
   } mix_result_type;

   // directed row: request plus optional typed-in result
   typedef struct packed {
      mix_request_type req;
      logic            known;
      mix_result_type  res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_func = '0;
   logic [3:0] req_pitch_class = '0;
   logic signed [15:0] req_voice0_left = '0, req_voice0_right = '0;
   logic signed [15:0] req_voice1_left = '0, req_voice1_right = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_mix_left, rsp_mix_right;
   logic rsp_voice0_on, rsp_voice1_on;
   logic [3:0] rsp_voice0_note, rsp_voice1_note;
   logic rsp_restart_voice0, rsp_restart_voice1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [FRAME_W-1:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   two_voice_crossfade_mixer_top dut (.*);

   // mixer model state
   logic [15:0] m_volume;
   logic [19:0] m_xfade, m_release, m_fast;
   logic [11:0] m_loaded;
   logic        m_enabled;
   logic [3:0]  m_last;
   logic        m_active [2];
   logic [63:0] m_gain [2];
   logic        m_up [2];
   longint      m_ramp [2];
   logic [3:0]  m_pitch [2];

   mix_result_type expected_mix [$];
   int errors = 0;
   int results_seen = 0;
   int frames_sent = 0;
   int note_ons_sent = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;

   function automatic longint ramp_len(logic [63:0] num, logic [19:0] frames);
      logic [63:0] d;
      d = (frames == 0) ? 64'd1 : {44'd0, frames};
      return longint'((num + d - 1) / d);
   endfunction

   function automatic logic signed [15:0] round_sat(longint acc);
      longint q;
      q = (acc + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   task automatic fade_voices(logic [19:0] frames);
      for (int i = 0; i < 2; i++)
         if (m_active[i]) begin
            m_up[i] = 1'b0;
            m_ramp[i] = -ramp_len(m_gain[i], frames);
         end
   endtask

   task automatic mixer_reset();
      m_volume = 16'd16384; m_xfade = 20'd72000; m_release = 20'd120000;
      m_fast = 20'd4800; m_loaded = '0; m_enabled = 1'b0; m_last = NO_NOTE;
      for (int i = 0; i < 2; i++) begin
         m_active[i] = 0; m_gain[i] = 0; m_up[i] = 0; m_ramp[i] = 0; m_pitch[i] = 0;
      end
   endtask

   task automatic mixer_step(input mix_request_type r, output mix_result_type res);
      longint accl, accr, g, tgt, fg;
      logic signed [15:0] sl, sr;
      int pick, freev;
      logic [63:0] low;
      res = '0;
      accl = 0; accr = 0;
      case (r.func)
         FUNC_FRAME: begin
            for (int i = 0; i < 2; i++) begin
               if (!m_active[i]) continue;
               tgt = m_up[i] ? longint'(ONE_GAIN) : 0;
               g = longint'(m_gain[i]);
               if (m_ramp[i] > 0 && g < tgt) begin
                  g += m_ramp[i];
                  if (g > tgt) g = tgt;
               end else if (m_ramp[i] < 0 && g > tgt) begin
                  g += m_ramp[i];
                  if (g < tgt) g = tgt;
               end
               m_gain[i] = 64'(g);
               fg = (g * longint'(m_volume) + 16384) >>> 15;
               sl = (i == 0) ? r.v0l : r.v1l;
               sr = (i == 0) ? r.v0r : r.v1r;
               accl += longint'(sl) * fg;
               accr += longint'(sr) * fg;
               if (!m_up[i] && m_gain[i] <= FREE_LEVEL) m_active[i] = 1'b0;
            end
            res.left = round_sat(accl);
            res.right = round_sat(accr);
         end
         FUNC_NOTE_ON: begin
            if (m_enabled && r.pitch <= MAX_PITCH && m_loaded[r.pitch] && r.pitch != m_last)
            begin
               pick = 0; freev = -1; low = '1;
               for (int i = 0; i < 2; i++)
                  if (m_active[i] && m_gain[i] < low) begin
                     low = m_gain[i]; pick = i;
                  end
               fade_voices(m_xfade);
               for (int i = 1; i >= 0; i--)
                  if (!m_active[i]) freev = i;
               if (freev >= 0) pick = freev;
               m_pitch[pick] = r.pitch; m_gain[pick] = 0; m_up[pick] = 1'b1;
               m_ramp[pick] = ramp_len(64'(ONE_GAIN), m_xfade);
               m_active[pick] = 1'b1; m_last = r.pitch;
               if (pick == 0) res.rs0 = 1'b1; else res.rs1 = 1'b1;
            end
         end
         FUNC_NOTE_OFF: begin
            m_last = NO_NOTE;
            fade_voices(m_release);
         end
         FUNC_KILL: begin
            m_last = NO_NOTE;
            for (int i = 0; i < 2; i++)
               if (m_active[i]) begin
                  m_gain[i] = 0; m_up[i] = 0; m_active[i] = 0;
               end
         end
         FUNC_ENABLE: m_enabled = 1'b1;
         FUNC_DISABLE: begin
            m_enabled = 1'b0;
            for (int i = 0; i < 2; i++) begin
               m_up[i] = 1'b0;
               m_ramp[i] = -ramp_len(64'(ONE_GAIN), m_fast);
            end
            m_last = NO_NOTE;
         end
         default: ;
      endcase
      res.on0 = m_active[0]; res.on1 = m_active[1];
      res.note0 = m_pitch[0]; res.note1 = m_pitch[1];
   endtask

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on response %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
   endtask

   task automatic idle_gap();
      int n;
      if ($urandom_range(0, 2) != 0) return;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(mix_request_type r);
      mix_result_type res;
      // valid is still being dropped for the previous request in this step
      if (req_valid) @(posedge clock);
      mixer_step(r, res);
      expected_mix.push_back(res);
      if (r.func == FUNC_FRAME) frames_sent++;
      if (r.func == FUNC_NOTE_ON) note_ons_sent++;
      req_valid <= 1'b1;
      req_func <= r.func; req_pitch_class <= r.pitch;
      req_voice0_left <= r.v0l; req_voice0_right <= r.v0r;
      req_voice1_left <= r.v1l; req_voice1_right <= r.v1r;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(reg_index_type idx, logic [19:0] data);
      if (csr_valid) @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MASTER_VOLUME: m_volume = data[15:0];
         REG_CROSSFADE:     m_xfade = data;
         REG_RELEASE:       m_release = data;
         REG_FAST_FADE:     m_fast = data;
         REG_LOADED_MASK:   m_loaded = data[11:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic mix_request_type rand_request(bit mostly_valid);
      mix_request_type r;
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) r.func = FUNC_FRAME;
      else if (k < 75) r.func = FUNC_NOTE_ON;
      else if (k < 83) r.func = FUNC_NOTE_OFF;
      else if (k < 86) r.func = FUNC_KILL;
      else if (k < 92) r.func = FUNC_ENABLE;
      else if (k < 96) r.func = FUNC_DISABLE;
      else r.func = 3'($urandom_range(0, 7));
      r.pitch = mostly_valid ? 4'($urandom_range(0, 11)) : 4'($urandom_range(0, 15));
      k = $urandom_range(0, 9);
      r.v0l = (k == 0) ? 16'sh8000 : (k == 1) ? 16'sh7fff : 16'($urandom);
      r.v0r = 16'($urandom);
      r.v1l = 16'($urandom);
      r.v1r = (k == 2) ? 16'sh8000 : (k == 3) ? 16'sh7fff : 16'($urandom);
      return r;
   endfunction

   // result checking
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mix.size() == 0) begin
            errors++;
            $display("unexpected response %0d", results_seen);
         end else begin
            want = expected_mix.pop_front();
            if (rsp_mix_left !== want.left) report_mismatch("mix_left", rsp_mix_left, want.left);
            if (rsp_mix_right !== want.right)
               report_mismatch("mix_right", rsp_mix_right, want.right);
            if (rsp_voice0_on !== want.on0) report_mismatch("voice0_on", rsp_voice0_on, want.on0);
            if (rsp_voice1_on !== want.on1) report_mismatch("voice1_on", rsp_voice1_on, want.on1);
            if (rsp_voice0_note !== want.note0)
               report_mismatch("voice0_note", rsp_voice0_note, want.note0);
            if (rsp_voice1_note !== want.note1)
               report_mismatch("voice1_note", rsp_voice1_note, want.note1);
            if (rsp_restart_voice0 !== want.rs0)
               report_mismatch("restart_voice0", rsp_restart_voice0, want.rs0);
            if (rsp_restart_voice1 !== want.rs1)
               report_mismatch("restart_voice1", rsp_restart_voice1, want.rs1);
         end
         results_seen++;
      end
   end

   // receiver with random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   initial begin
      @(posedge clock);
      wait (frames_sent > 400);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // watchdog: cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type rows [$];
      mix_request_type r;
      int tail;
      mixer_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(REG_LOADED_MASK, 20'hfff);
      csr_write(REG_CROSSFADE, 20'd4);
      csr_write(REG_RELEASE, 20'd3);
      csr_write(REG_FAST_FADE, 20'd2);
      csr_write(REG_MASTER_VOLUME, 20'd32768);

      // after reset: disabled note-on rejected, frames silent
      rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b1, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd3, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '0});
      rows.push_back('{'{FUNC_ENABLE, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd12, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd15, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                       '{16'sd0, 16'sd0, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1, 1'b0}});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      for (int i = 0; i < 5; i++)
         rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh7fff, 16'sh8000, 16'sh1234, 16'sh8000},
                          1'b0, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd11, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000},
                       1'b0, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd5, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
                       1'b0, '0});
      rows.push_back('{'{FUNC_NOTE_OFF, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      for (int i = 0; i < 4; i++)
         rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh4000, 16'shc000, 16'sh7fff, 16'sh8000},
                          1'b0, '0});
      rows.push_back('{'{FUNC_NOTE_ON, 4'd7, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      rows.push_back('{'{FUNC_DISABLE, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      rows.push_back('{'{FUNC_FRAME, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
                       1'b0, '0});
      rows.push_back('{'{3'd6, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});
      rows.push_back('{'{FUNC_KILL, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                       '{16'sd0, 16'sd0, 1'b0, 1'b0, 4'd7, 4'd5, 1'b0, 1'b0}});
      rows.push_back('{'{3'd7, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0});

      foreach (rows[i]) begin
         mix_result_type probe_save;
         send_request(rows[i].req);
         // typed-in rows must agree with the prediction just queued
         probe_save = expected_mix[$];
         if (rows[i].known && probe_save !== rows[i].res) begin
            errors++;
            $display("directed row %0d: table and prediction disagree", i);
         end
      end
      drain();

      // random phases over several register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(REG_MASTER_VOLUME, 20'd0);
               csr_write(REG_CROSSFADE, 20'd1);
               csr_write(REG_RELEASE, 20'd1);
               csr_write(REG_FAST_FADE, 20'd1);
            end
            1: begin
               csr_write(REG_MASTER_VOLUME, 20'd65535);
               csr_write(REG_CROSSFADE, 20'd0);
               csr_write(REG_RELEASE, 20'd0);
               csr_write(REG_FAST_FADE, 20'd0);
               csr_write(REG_LOADED_MASK, 20'h0a5a);
            end
            2: begin
               csr_write(REG_MASTER_VOLUME, 20'd16384);
               csr_write(REG_CROSSFADE, 20'hfffff);
               csr_write(REG_RELEASE, 20'hfffff);
               csr_write(REG_FAST_FADE, 20'hfffff);
               csr_write(REG_LOADED_MASK, 20'h0fff);
            end
            3: begin
               csr_write(REG_MASTER_VOLUME, 20'd32768);
               csr_write(REG_CROSSFADE, 20'd8);
               csr_write(REG_RELEASE, 20'd12);
               csr_write(REG_FAST_FADE, 20'd5);
               csr_write(REG_LOADED_MASK, 20'h0000);
            end
            4: begin
               csr_write(REG_LOADED_MASK, 20'h0fff);
               csr_write(REG_MASTER_VOLUME, 20'($urandom_range(0, 65535)));
               csr_write(REG_CROSSFADE, 20'($urandom_range(1, 40)));
               csr_write(REG_RELEASE, 20'($urandom_range(1, 40)));
               csr_write(REG_FAST_FADE, 20'($urandom_range(1, 20)));
            end
            default: begin
               csr_write(REG_MASTER_VOLUME, 20'd32768);
               csr_write(REG_CROSSFADE, 20'd3);
               csr_write(REG_RELEASE, 20'd6);
               csr_write(REG_FAST_FADE, 20'd2);
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            r = rand_request($urandom_range(0, 4) != 0);
            send_request(r);
            idle_gap();
         end
         drain();
      end
      stim_done = 1'b1;

      tail = 0;
      while (expected_mix.size() != 0 && tail < 5000) begin
         @(posedge clock);
         tail++;
      end
      if (expected_mix.size() != 0) begin
         errors++;
         $display("%0d responses never arrived", expected_mix.size());
      end
      $display("covered %0d responses: %0d frames, %0d note-ons, all register extremes",
               results_seen, frames_sent, note_ons_sent);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tvx_pkg.sv
rtl/core/tvx_div.sv
rtl/core/two_voice_crossfade_mixer_top.sv
tb/tb_top.sv
